>>> rtl/hciev_pkg.sv
// Shared types and constants for the HCI event reassembler.
`timescale 1ns / 1ps

package hciev_pkg;

  localparam int EVENT_CAP        = 257;
  localparam int RIDX_W           = 9;
  localparam int HEADER_BYTES     = 2;
  localparam int ANSWER_MIN_BYTES = 6;

  localparam logic [7:0] CODE_CMD_COMPLETE = 8'h0E;
  localparam logic [7:0] CODE_CMD_STATUS   = 8'h0F;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    ANS_NONE     = 2'd0,
    ANS_COMPLETE = 2'd1,
    ANS_STATUS   = 2'd2
  } answer_kind_t;

  typedef struct packed {
    logic              operation;
    logic [7:0]        data_byte;
    logic              last_of_packet;
    logic [RIDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic         packet_end;
    logic         event_complete;
    logic         overrun;
    logic [7:0]   event_code;
    logic [7:0]   parameter_length;
    answer_kind_t answer_kind;
    logic [15:0]  answer_opcode;
    logic [7:0]   answer_status;
    logic [7:0]   read_data;
    logic [15:0]  completed_total;
    logic [15:0]  overrun_total;
  } result_t;

  // Result of the tracker stage; read_data is filled in from the store later.
  typedef struct packed {
    result_t res;
    logic    rd_hit;
  } step_t;

endpackage

>>> rtl/hciev_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module hciev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> rtl/hciev_tracker.sv
// Event state tracking, header shadow bytes and the event store.
`timescale 1ns / 1ps

module hciev_tracker #(
  parameter int EVENT_CAPACITY = hciev_pkg::EVENT_CAP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  hciev_pkg::item_t   item,
  output hciev_pkg::step_t   step,
  output logic [7:0]         rd_data
);

  import hciev_pkg::*;

  localparam int CNT_W  = $clog2(EVENT_CAPACITY + 1);
  localparam int ADDR_W = $clog2(EVENT_CAPACITY);
  localparam int CMP_W  = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam int SHADOW = ANSWER_MIN_BYTES;

  logic [CNT_W-1:0] held_count, held_count_next;
  logic [CNT_W-1:0] expected_length, expected_length_next;
  logic             capacity_exceeded, capacity_exceeded_next;
  logic             packet_open, packet_open_next;
  logic [15:0]      completed_count, completed_count_next;
  logic [15:0]      overrun_count, overrun_count_next;
  logic [7:0]       hdr [SHADOW];
  logic [7:0]       hdr_next [SHADOW];

  logic             is_feed;
  logic             clear_first;
  logic [CNT_W-1:0] h0, h1, e0, e1;
  logic             cap0, cap1;
  logic             wr;
  logic             rd_hit;
  logic             mem_en;
  logic [ADDR_W-1:0] mem_addr;
  result_t          res;

  assign is_feed = (item.operation == OP_FEED);

  always_comb begin
    clear_first = !packet_open && (expected_length != '0) &&
                  (held_count >= expected_length);
    h0   = clear_first ? '0 : held_count;
    e0   = clear_first ? '0 : expected_length;
    cap0 = clear_first ? 1'b0 : capacity_exceeded;

    wr   = (h0 < CNT_W'(EVENT_CAPACITY));
    cap1 = cap0 | ~wr;
    h1   = wr ? h0 + CNT_W'(1) : h0;

    for (int i = 0; i < SHADOW; i++) begin
      hdr_next[i] = (wr && (h0 == CNT_W'(i))) ? item.data_byte : hdr[i];
    end

    e1 = CNT_W'(HEADER_BYTES) + CNT_W'(hdr_next[1]);

    res                  = '0;
    res.answer_kind      = ANS_NONE;
    held_count_next      = h1;
    expected_length_next = e0;
    capacity_exceeded_next = cap1;
    packet_open_next     = 1'b1;
    completed_count_next = completed_count;
    overrun_count_next   = overrun_count;

    if (item.last_of_packet) begin
      packet_open_next = 1'b0;
      res.packet_end   = 1'b1;
      if (cap1) begin
        overrun_count_next     = overrun_count + 16'd1;
        res.overrun            = 1'b1;
        held_count_next        = '0;
        expected_length_next   = '0;
        capacity_exceeded_next = 1'b0;
      end else if (h1 >= CNT_W'(HEADER_BYTES)) begin
        expected_length_next = e1;
        if (h1 > e1) begin
          overrun_count_next     = overrun_count + 16'd1;
          res.overrun            = 1'b1;
          held_count_next        = '0;
          expected_length_next   = '0;
          capacity_exceeded_next = 1'b0;
        end else if (h1 == e1) begin
          completed_count_next = completed_count + 16'd1;
          res.event_complete   = 1'b1;
          res.event_code       = hdr_next[0];
          res.parameter_length = hdr_next[1];
          if (h1 >= CNT_W'(ANSWER_MIN_BYTES)) begin
            if (hdr_next[0] == CODE_CMD_COMPLETE) begin
              res.answer_kind   = ANS_COMPLETE;
              res.answer_opcode = {hdr_next[4], hdr_next[3]};
              res.answer_status = hdr_next[5];
            end else if (hdr_next[0] == CODE_CMD_STATUS) begin
              res.answer_kind   = ANS_STATUS;
              res.answer_opcode = {hdr_next[5], hdr_next[4]};
              res.answer_status = hdr_next[2];
            end
          end
        end
      end
    end

    if (!is_feed) begin
      res                  = '0;
      res.answer_kind      = ANS_NONE;
      completed_count_next = completed_count;
      overrun_count_next   = overrun_count;
    end
    res.completed_total = completed_count_next;
    res.overrun_total   = overrun_count_next;
  end

  assign rd_hit = !is_feed &&
                  (CMP_W'(item.read_index) < CMP_W'(held_count));
  assign step   = '{res: res, rd_hit: rd_hit};

  assign mem_en   = accept && (is_feed ? wr : rd_hit);
  assign mem_addr = is_feed ? h0[ADDR_W-1:0] : item.read_index[ADDR_W-1:0];

  hciev_ram #(
    .WIDTH(8),
    .DEPTH(EVENT_CAPACITY)
  ) u_store (
    .clk  (clk),
    .en   (mem_en),
    .we   (is_feed),
    .addr (mem_addr),
    .wdata(item.data_byte),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count        <= '0;
      expected_length   <= '0;
      capacity_exceeded <= 1'b0;
      packet_open       <= 1'b0;
      completed_count   <= '0;
      overrun_count     <= '0;
    end else if (accept && is_feed) begin
      held_count        <= held_count_next;
      expected_length   <= expected_length_next;
      capacity_exceeded <= capacity_exceeded_next;
      packet_open       <= packet_open_next;
      completed_count   <= completed_count_next;
      overrun_count     <= overrun_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_feed) begin
      for (int i = 0; i < SHADOW; i++) begin
        hdr[i] <= hdr_next[i];
      end
    end
  end

endmodule

>>> rtl/hci_event_reassembler_core.sv
// Top level of the HCI event reassembler: tracker, store read stage and result register.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+----------------------
//   item     | item_valid   | item_stall   | item   (item_t)
//   result   | result_valid | result_stall | result (result_t)
//
// One item per cycle unless a result stall holds it; each result is registered
// in s1, beside the registered read of the event store, and then in result.
// Reset clears event state, counters and both stage valids; the store is
// not cleared. A stalled result holds the second stage, which then stalls
// the item side; no transfer is lost.
`timescale 1ns / 1ps

module hci_event_reassembler_core #(
  parameter int EVENT_CAPACITY = hciev_pkg::EVENT_CAP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  hciev_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output hciev_pkg::result_t result
);

  import hciev_pkg::*;

  logic       accept;
  logic       advance;
  step_t      step;
  logic [7:0] rd_data;
  logic       s1_valid;
  step_t      s1;
  result_t    s1_out;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;

  hciev_tracker #(
    .EVENT_CAPACITY(EVENT_CAPACITY)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .step   (step),
    .rd_data(rd_data)
  );

  always_comb begin
    s1_out           = s1.res;
    s1_out.read_data = s1.rd_hit ? rd_data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
      if (advance) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= step;
    end
    if (advance && s1_valid) begin
      result <= s1_out;
    end
  end

endmodule

>>> tb/sv/tb_hci_event_reassembler_check.sv
// Checker for the HCI event reassembler: predicts each result and compares it on transfer.
`timescale 1ns / 1ps

module tb_hci_event_reassembler_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  hciev_pkg::item_t   item,
  input  logic               result_valid,
  input  logic               result_stall,
  input  hciev_pkg::result_t result,
  output int                 fails,
  output int                 awaiting,
  output int                 n_checked,
  output int                 n_events,
  output int                 n_answers,
  output int                 n_overruns
);

  import hciev_pkg::*;

  logic [7:0]  ev_bytes [0:EVENT_CAP-1];
  int unsigned held;
  int unsigned decl_len;
  bit          cap_hit;
  bit          pkt_open;
  logic [15:0] n_complete;
  logic [15:0] n_overrun;

  result_t expected_results[$];

  function automatic void drop_event();
    held = 0;
    decl_len = 0;
    cap_hit = 1'b0;
  endfunction

  function automatic result_t reassemble(item_t it);
    result_t r;
    r = '0;
    if (it.operation == OP_READ) begin
      if (it.read_index < held) r.read_data = ev_bytes[it.read_index];
    end else begin
      // first byte of a new packet discards an event that is already whole
      if (!pkt_open && decl_len != 0 && held >= decl_len) drop_event();
      pkt_open = 1'b1;
      if (held >= EVENT_CAP) begin
        cap_hit = 1'b1;
      end else begin
        ev_bytes[held] = it.data_byte;
        held++;
      end
      if (it.last_of_packet) begin
        pkt_open = 1'b0;
        r.packet_end = 1'b1;
        if (cap_hit) begin
          n_overrun++;
          drop_event();
          r.overrun = 1'b1;
        end else if (held >= HEADER_BYTES) begin
          decl_len = HEADER_BYTES + ev_bytes[1];
          if (held > decl_len) begin
            n_overrun++;
            drop_event();
            r.overrun = 1'b1;
          end else if (held == decl_len) begin
            n_complete++;
            r.event_complete = 1'b1;
            r.event_code = ev_bytes[0];
            r.parameter_length = ev_bytes[1];
            if (held >= ANSWER_MIN_BYTES) begin
              if (ev_bytes[0] == CODE_CMD_COMPLETE) begin
                r.answer_kind = ANS_COMPLETE;
                r.answer_opcode = {ev_bytes[4], ev_bytes[3]};
                r.answer_status = ev_bytes[5];
              end else if (ev_bytes[0] == CODE_CMD_STATUS) begin
                r.answer_kind = ANS_STATUS;
                r.answer_opcode = {ev_bytes[5], ev_bytes[4]};
                r.answer_status = ev_bytes[2];
              end
            end
          end
        end
      end
    end
    r.completed_total = n_complete;
    r.overrun_total = n_overrun;
    return r;
  endfunction

  function automatic string show(result_t r);
    return {$sformatf("end=%0b cmp=%0b ovr=%0b code=%02h plen=%02h kind=%0d op=%04h st=%02h",
                      r.packet_end, r.event_complete, r.overrun, r.event_code,
                      r.parameter_length, r.answer_kind, r.answer_opcode, r.answer_status),
            $sformatf(" rd=%02h nc=%0d no=%0d", r.read_data, r.completed_total,
                      r.overrun_total)};
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      drop_event();
      pkt_open = 1'b0;
      n_complete = '0;
      n_overrun = '0;
      expected_results.delete();
      fails = 0;
      n_checked = 0;
      n_events = 0;
      n_answers = 0;
      n_overruns = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          if (fails < 10) $display("unexpected result transfer: %s", show(result));
          fails++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (want.event_complete) n_events++;
          if (want.answer_kind != ANS_NONE) n_answers++;
          if (want.overrun) n_overruns++;
          if (result !== want) begin
            if (fails < 10) begin
              $display("result mismatch");
              $display("  expected %s", show(want));
              $display("  actual   %s", show(result));
            end
            fails++;
          end
        end
      end
      if (item_valid && !item_stall) expected_results.push_back(reassemble(item));
    end
    awaiting = expected_results.size();
  end

endmodule

>>> tb/sv/tb_hci_event_reassembler_core.sv
// Testbench top for the HCI event reassembler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_hci_event_reassembler_core;
  import hciev_pkg::*;

  localparam int N_ITEMS   = 1200;
  localparam int PHASE_LEN = 150;
  localparam int LIMIT     = 300000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    result_stall = 1'b0;
  item_t   item = '0;
  logic    item_stall;
  logic    result_valid;
  result_t result;

  int fails, awaiting, n_checked, n_events, n_answers, n_overruns;
  int sent = 0;
  int cycles = 0;
  int cur_phase = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int idle_by_phase[4] = '{0, 55, 0, 15};
  int stall_by_phase[4] = '{0, 0, 55, 15};

  hci_event_reassembler_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  tb_hci_event_reassembler_check u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fails        (fails),
    .awaiting     (awaiting),
    .n_checked    (n_checked),
    .n_events     (n_events),
    .n_answers    (n_answers),
    .n_overruns   (n_overruns)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timed out with %0d results outstanding", awaiting);
      $display("[hci_event_reassembler_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic transfer(input item_t it);
    int phase;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sent++;
    phase = (sent / PHASE_LEN) % 4;
    if (phase != cur_phase) begin
      // drain everything before the idling pattern changes
      cur_phase = phase;
      @(negedge clk);
      item_valid <= 1'b0;
      while (awaiting != 0) @(negedge clk);
      idle_pct = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    item_t it;
    it.operation = OP_FEED;
    it.data_byte = b;
    it.last_of_packet = last;
    it.read_index = RIDX_W'($urandom_range(0, 511));
    transfer(it);
  endtask

  task automatic peek(input int idx);
    item_t it;
    it.operation = OP_READ;
    it.data_byte = 8'($urandom_range(0, 255));
    it.last_of_packet = 1'($urandom_range(0, 1));
    it.read_index = idx[RIDX_W-1:0];
    transfer(it);
  endtask

  // One event cut into packets at random; the first surplus byte always shares the
  // packet that reaches the declared length, so it gives an overrun.
  task automatic send_event(input logic [7:0] code, input int plen, input int extra);
    int total;
    int pos;
    int chunk;
    logic [7:0] b;
    total = HEADER_BYTES + plen + extra;
    pos = 0;
    while (pos < total) begin
      if ($urandom_range(0, 3) == 0) chunk = total - pos;
      else chunk = $urandom_range(1, 8);
      if (extra > 0 && pos < HEADER_BYTES + plen && pos + chunk == HEADER_BYTES + plen)
        chunk++;
      if (chunk > total - pos) chunk = total - pos;
      for (int k = 0; k < chunk; k++) begin
        if (pos == 0) b = code;
        else if (pos == 1) b = plen[7:0];
        else b = 8'($urandom_range(0, 255));
        push_byte(b, k == chunk - 1);
        pos++;
      end
    end
  endtask

  initial begin
    int sel;
    int plen;
    logic [7:0] code;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    peek(0);
    push_byte(8'h0E, 1'b0);
    push_byte(8'h04, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h0C, 1'b0);
    push_byte(8'h00, 1'b1);
    peek(5);
    peek(6);
    peek(511);
    push_byte(8'h0F, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h04, 1'b1);
    // lone byte: header not yet known, stays pending
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h3E, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b1);
    // command complete too short to carry an answer
    push_byte(CODE_CMD_COMPLETE, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);

    // full store, then one that runs past the capacity
    send_event(CODE_CMD_COMPLETE, 255, 0);
    peek(256);
    peek(0);
    send_event(CODE_CMD_STATUS, 255, 3);

    while (sent < N_ITEMS) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       code = CODE_CMD_COMPLETE;
        1:       code = CODE_CMD_STATUS;
        default: code = 8'($urandom_range(0, 255));
      endcase
      plen = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
      if (sel < 70) begin
        send_event(code, plen, 0);
        repeat ($urandom_range(0, 3)) peek($urandom_range(0, plen + 3));
      end else if (sel < 85) begin
        send_event(code, plen, $urandom_range(1, 4));
      end else if (sel < 95) begin
        repeat ($urandom_range(1, 6))
          push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        peek($urandom_range(0, 511));
      end
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d items sent, %0d results checked over four idling patterns", sent, n_checked);
    $display("%0d events completed (%0d command answers), %0d overruns",
             n_events, n_answers, n_overruns);
    if (fails == 0) begin
      $display("[hci_event_reassembler_core] OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("[hci_event_reassembler_core] ERROR");
    end
    $finish;
  end

endmodule
